[src/pwu_pkg.sv]
// Package: formats, payload structs and conversion functions for the unpacker
`timescale 1ns / 1ps
`default_nettype none
package pwu_pkg;

  localparam logic [3:0] FMT_FP16   = 4'd0;
  localparam logic [3:0] FMT_BF16   = 4'd1;
  localparam logic [3:0] FMT_FP32   = 4'd2;
  localparam logic [3:0] FMT_INT8   = 4'd3;
  localparam logic [3:0] FMT_UINT8  = 4'd4;
  localparam logic [3:0] FMT_INT32  = 4'd5;
  localparam logic [3:0] FMT_RAW8   = 4'd6;
  localparam logic [3:0] FMT_RAW16  = 4'd7;
  localparam logic [3:0] FMT_RAW32  = 4'd8;
  localparam logic [3:0] FMT_UINT16 = 4'd9;

  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic [31:0] packed_word;
    logic        last_in;
  } pwu_in_t;

  typedef struct packed {
    logic [31:0] lane0_bits;
    logic [31:0] lane1_bits;
    logic [31:0] lane2_bits;
    logic [31:0] lane3_bits;
    logic [2:0]  lane_count;
    logic        last_out;
  } pwu_out_t;

  // 32-bit leading one position
  function automatic logic [4:0] lead_one(input logic [31:0] a);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (a[i]) p = 5'(i);
    end
    return p;
  endfunction

  // sign and magnitude to fp32, round to nearest even
  function automatic logic [31:0] mag_to_fp32(input logic neg, input logic [31:0] a);
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] mant;
    logic [7:0]  ex;
    logic        g;
    logic        st;
    p    = lead_one(a);
    norm = a << (5'd31 - p);
    g    = norm[7];
    st   = |norm[6:0];
    mant = {1'b0, norm[31:8]};
    if (g && (st || norm[8])) mant = mant + 25'd1;
    ex = 8'(p) + 8'd127;
    if (mant[24]) begin
      mant = mant >> 1;
      ex   = ex + 8'd1;
    end
    if (a == 32'd0) return 32'd0;
    return {neg, ex, mant[22:0]};
  endfunction

  function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] mn;
    logic [7:0] ex;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = m << (4'd10 - p);
    ex = 8'd103 + 8'(p);
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, ex, mn, 13'd0};
    end
    if (e == 5'h1F) return {s, 8'hFF, m, 13'd0};
    return {s, 8'(e) + 8'h70, m, 13'd0};
  endfunction

endpackage
`default_nettype wire

[src/pwu_lane.sv]
// Lane: converts one element selected from the word to fp32 bits
`timescale 1ns / 1ps
`default_nettype none
module pwu_lane
  import pwu_pkg::*;
(
  input  wire logic [3:0]  fmt,
  input  wire logic [31:0] word_elem,
  output logic [31:0]      lane_bits
);
  logic [7:0]  b;
  logic [15:0] hw;
  logic [31:0] ineg;

  assign b    = word_elem[7:0];
  assign hw   = word_elem[15:0];
  assign ineg = 32'd0 - word_elem;

  always_comb begin
    case (fmt)
      FMT_FP16:   lane_bits = half_to_fp32(hw);
      FMT_BF16:   lane_bits = {hw, 16'd0};
      FMT_RAW16:  lane_bits = {16'd0, hw};
      FMT_UINT16: lane_bits = mag_to_fp32(1'b0, {16'd0, hw});
      FMT_INT8:   lane_bits = b[7] ? mag_to_fp32(1'b1, {24'd0, 8'(9'h100 - {1'b0, b})})
                                   : mag_to_fp32(1'b0, {24'd0, b});
      FMT_UINT8:  lane_bits = mag_to_fp32(1'b0, {24'd0, b});
      FMT_RAW8:   lane_bits = {24'd0, b};
      FMT_FP32, FMT_RAW32: lane_bits = word_elem;
      FMT_INT32:  lane_bits = word_elem[31] ? mag_to_fp32(1'b1, ineg)
                                            : mag_to_fp32(1'b0, word_elem);
      default:    lane_bits = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

[src/pwu_merge.sv]
// Merge: masks unused lanes and assembles the result transaction
`timescale 1ns / 1ps
`default_nettype none
module pwu_merge
  import pwu_pkg::*;
(
  input  wire logic [3:0]  fmt,
  input  wire logic [31:0] l0,
  input  wire logic [31:0] l1,
  input  wire logic [31:0] l2,
  input  wire logic [31:0] l3,
  input  wire logic        last_in,
  output pwu_out_t         res
);
  logic [2:0] cnt;
  always_comb begin
    case (fmt)
      FMT_FP16, FMT_BF16, FMT_RAW16, FMT_UINT16: cnt = 3'd2;
      FMT_INT8, FMT_UINT8, FMT_RAW8:             cnt = 3'd4;
      default:                                   cnt = 3'd1;
    endcase
    res.lane0_bits = l0;
    res.lane1_bits = (cnt >= 3'd2) ? l1 : 32'd0;
    res.lane2_bits = (cnt == 3'd4) ? l2 : 32'd0;
    res.lane3_bits = (cnt == 3'd4) ? l3 : 32'd0;
    res.lane_count = cnt;
    res.last_out   = last_in;
  end
endmodule
`default_nettype wire

[src/packed_word_to_fp32_unpacker.sv]
// Top level: packed word to fp32 unpacker with four conversion lanes
// channel | direction | handshake           | payload
// in      | input     | start, busy         | in_data (pwu_in_t)
// out     | output    | out_valid strobe    | out_data (pwu_out_t)
// cfg     | input     | cfg_valid, cfg_ready| cfg_data (format_select)
// One transaction per cycle; the result appears in the cycle after start.
// The single output register after the lanes holds the result.
// Reset clears the format to fp16 and the strobe; busy is always low.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module packed_word_to_fp32_unpacker
  import pwu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire pwu_in_t    in_data,
  output logic            out_valid,
  output pwu_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);
  logic [3:0]  fmt_r;
  logic        valid_r;
  pwu_out_t    res_r;
  pwu_out_t    res_nxt;
  logic [31:0] lb [NUM_LANES];
  logic [31:0] elem [NUM_LANES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    case (fmt_r)
      FMT_FP16, FMT_BF16, FMT_RAW16, FMT_UINT16: begin
        elem[0] = {16'd0, in_data.packed_word[15:0]};
        elem[1] = {16'd0, in_data.packed_word[31:16]};
      end
      default: begin
        elem[0] = in_data.packed_word;
        elem[1] = {24'd0, in_data.packed_word[15:8]};
      end
    endcase
    elem[2] = {24'd0, in_data.packed_word[23:16]};
    elem[3] = {24'd0, in_data.packed_word[31:24]};
  end

  genvar g;
  generate
    for (g = 0; g < NUM_LANES; g++) begin : g_lane
      pwu_lane u_lane (.fmt(fmt_r), .word_elem(elem[g]), .lane_bits(lb[g]));
    end
  endgenerate

  pwu_merge u_merge (
    .fmt(fmt_r), .l0(lb[0]), .l1(lb[1]), .l2(lb[2]), .l3(lb[3]),
    .last_in(in_data.last_in), .res(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_FP16;
      valid_r <= 1'b0;
    end else begin
      if (cfg_valid) fmt_r <= cfg_data;
      valid_r <= start;
    end
    if (start) res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;
endmodule
`default_nettype wire

[tb/tb_packed_word_to_fp32_unpacker.sv]
// Testbench: packed word to fp32 unpacker, checked against a predictor of the lane conversions
`timescale 1ns / 1ps
`default_nettype none
module tb_packed_word_to_fp32_unpacker;
  import pwu_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  pwu_in_t    in_data;
  logic       out_valid;
  pwu_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  packed_word_to_fp32_unpacker u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pwu_in_t    word_queue[$];
  pwu_out_t   lanes_expected[$];
  logic [3:0] cur_format;
  int         error_count;
  int         idle_pct;
  logic       hold_off;
  logic       sim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] int_to_single(input logic neg, input logic [31:0] a);
    int          msb;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] halfway;
    int          sh;
    if (a == 32'd0) return 32'd0;
    msb = 31;
    while (!a[msb]) msb--;
    if (msb <= 23) begin
      mant = a << (23 - msb);
    end else begin
      sh = msb - 23;
      mant = a >> sh;
      rem = a & ((32'd1 << sh) - 32'd1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && mant[0])) mant = mant + 32'd1;
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        msb++;
      end
    end
    return {neg, 8'(msb + 127), mant[22:0]};
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [9:0]  m;
    logic [7:0]  ex;
    logic [10:0] mw;
    m = h[9:0];
    if (h[14:10] == 5'd0) begin
      if (m == 10'd0) return {h[15], 31'd0};
      ex = 8'd113;
      mw = {1'b0, m};
      while (!mw[10]) begin
        mw = mw << 1;
        ex = ex - 8'd1;
      end
      return {h[15], ex, mw[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, m, 13'd0};
    return {h[15], 8'(h[14:10]) + 8'h70, m, 13'd0};
  endfunction

  function automatic pwu_out_t unpack_word(input logic [3:0] fmt, input pwu_in_t it);
    pwu_out_t    r;
    logic [31:0] lane [4];
    logic [31:0] w;
    logic [15:0] hw;
    logic [7:0]  b;
    w = it.packed_word;
    for (int i = 0; i < 4; i++) lane[i] = 32'd0;
    r.lane_count = 3'd1;
    case (fmt)
      FMT_FP16, FMT_BF16, FMT_RAW16, FMT_UINT16: begin
        r.lane_count = 3'd2;
        for (int i = 0; i < 2; i++) begin
          hw = w[16*i +: 16];
          case (fmt)
            FMT_FP16: lane[i] = half_to_single(hw);
            FMT_BF16: lane[i] = {hw, 16'd0};
            FMT_RAW16: lane[i] = {16'd0, hw};
            default: lane[i] = int_to_single(1'b0, {16'd0, hw});
          endcase
        end
      end
      FMT_INT8, FMT_UINT8, FMT_RAW8: begin
        r.lane_count = 3'd4;
        for (int i = 0; i < 4; i++) begin
          b = w[8*i +: 8];
          if (fmt == FMT_INT8) begin
            if (b[7]) lane[i] = int_to_single(1'b1, 32'h100 - {24'd0, b});
            else lane[i] = int_to_single(1'b0, {24'd0, b});
          end else if (fmt == FMT_UINT8) begin
            lane[i] = int_to_single(1'b0, {24'd0, b});
          end else begin
            lane[i] = {24'd0, b};
          end
        end
      end
      FMT_FP32, FMT_RAW32: lane[0] = w;
      FMT_INT32: begin
        if (w[31]) lane[0] = int_to_single(1'b1, 32'd0 - w);
        else lane[0] = int_to_single(1'b0, w);
      end
      default: ;
    endcase
    r.lane0_bits = lane[0];
    r.lane1_bits = lane[1];
    r.lane2_bits = lane[2];
    r.lane3_bits = lane[3];
    r.last_out = it.last_in;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (fmt %0d)", what, got, want, cur_format);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) lanes_expected.insert(lanes_expected.size(), unpack_word(cur_format, in_data));
      if (word_queue.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
        in_data <= word_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pwu_out_t want;
    if (rst_n && out_valid) begin
      if (lanes_expected.size() == 0) begin
        report_mismatch("unexpected result", out_data.lane0_bits, 32'd0);
      end else begin
        want = lanes_expected.pop_front();
        if (out_data.lane0_bits !== want.lane0_bits)
          report_mismatch("lane0", out_data.lane0_bits, want.lane0_bits);
        if (out_data.lane1_bits !== want.lane1_bits)
          report_mismatch("lane1", out_data.lane1_bits, want.lane1_bits);
        if (out_data.lane2_bits !== want.lane2_bits)
          report_mismatch("lane2", out_data.lane2_bits, want.lane2_bits);
        if (out_data.lane3_bits !== want.lane3_bits)
          report_mismatch("lane3", out_data.lane3_bits, want.lane3_bits);
        if (out_data.lane_count !== want.lane_count)
          report_mismatch("lane_count", 32'(out_data.lane_count), 32'(want.lane_count));
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", 32'(out_data.last_out), 32'(want.last_out));
      end
    end
  end

  task automatic drain();
    while (word_queue.size() > 0 || start) @(posedge clk);
    while (lanes_expected.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input logic [3:0] fmt);
    cfg_data <= fmt;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_format = fmt;
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0: w = 32'd0;
      1: w = 32'hFFFF_FFFF;
      2: w = {w[31], 31'd0};
      3: w = {16'd0, w[15:0]} & 32'h83FF_83FF;
      4: w = w | 32'h7C00_7C00;
      default: ;
    endcase
    return w;
  endfunction

  task automatic queue_word(input logic [31:0] w);
    pwu_in_t it;
    it.packed_word = w;
    it.last_in = $urandom_range(1);
    word_queue.insert(word_queue.size(), it);
  endtask

  initial begin
    logic [31:0] directed [13];
    logic [3:0]  fmt;
    directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_8000, 32'h0001_83FF,
                 32'h7C00_FC00, 32'h7E01_7C01, 32'h7BFF_0400, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0001, 32'h0100_0001, 32'h0300_0003,
                 32'h8080_7F7F};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_format = FMT_FP16;
    error_count = 0;
    idle_pct = 29;
    hold_off = 1'b0;
    sim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int w = 0; w < 13; w++) queue_word(directed[w]);
    drain();
    for (int f = 0; f < 16; f++) begin
      write_format(4'(f));
      for (int w = 0; w < 13; w++) queue_word(directed[w]);
      drain();
    end
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 75 : 0;
      for (int blk = 0; blk < 14; blk++) begin
        fmt = (blk < 12) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10));
        if (blk == 0) fmt = (ph == 0) ? 4'd0 : 4'd9;
        write_format(fmt);
        for (int k = 0; k < 24; k++) queue_word(random_word());
        if (blk == 5) begin
          while (word_queue.size() > 15) @(posedge clk);
          hold_off = 1'b1;
          while (start || lanes_expected.size() > 0) @(posedge clk);
          repeat (3) @(posedge clk);
          hold_off = 1'b0;
        end
        drain();
      end
    end
    write_format(4'd15);
    write_format(FMT_FP16);
    drain();
    sim_done = 1'b1;
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    if (!sim_done) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire

[sim.f]
src/pwu_pkg.sv
src/pwu_lane.sv
src/pwu_merge.sv
src/packed_word_to_fp32_unpacker.sv
tb/tb_packed_word_to_fp32_unpacker.sv
